### rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only while the block is out of reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked only while the block is out of reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mtsb_pkg.sv
package mtsb_pkg;

    localparam int unsigned MT_N  = 624;
    localparam int unsigned MT_M  = 397;
    localparam int unsigned MT_AW = 10;

    localparam logic [31:0] MT_UPPER    = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER    = 32'h7fff_ffff;
    localparam logic [31:0] MT_MATRIX   = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C = 32'hefc6_0000;
    localparam logic [31:0] BASE_SEED   = 32'd19650218;
    localparam logic [31:0] MULT_BASE   = 32'd1812433253;
    localparam logic [31:0] MULT_MIX1   = 32'd1664525;
    localparam logic [31:0] MULT_MIX2   = 32'd1566083941;

    localparam logic [1:0] KIND_SEED    = 2'd0;
    localparam logic [1:0] KIND_RAW     = 2'd1;
    localparam logic [1:0] KIND_BOUNDED = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_SEED_FIN,
        ST_DRAW_RN,
        ST_DRAW_RF,
        ST_DRAW_CMP
    } mtsb_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] seed;
        logic [31:0] limit;
        logic [5:0]  bits;
    } mtsb_cmd_t;

    typedef struct packed {
        logic        ready;
        logic        res_valid;
        logic [31:0] res_value;
    } mtsb_stat_t;

    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

### rtl/core/mtsb_word_ram.sv
module mtsb_word_ram #(
    parameter int unsigned DEPTH = 624,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/mtsb_core.sv
module mtsb_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  mtsb_pkg::mtsb_cmd_t cmd,
    input  logic               out_free,
    output mtsb_pkg::mtsb_stat_t stat
);
    import mtsb_pkg::*;

    mtsb_state_t state_reg, state_next;

    logic [MT_AW-1:0] pos_reg, pos_next;
    logic [MT_AW-1:0] idx_reg, idx_next;
    logic [MT_AW-1:0] cnt_reg, cnt_next;
    logic             pass_reg, pass_next;
    logic             wrap_reg, wrap_next;
    logic [31:0]      p_reg, p_next;
    logic [31:0]      b_reg, b_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      bprod_reg, bprod_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      cur_reg, cur_next;
    logic [31:0]      nw_reg, nw_next;
    logic [1:0]       kind_reg, kind_next;
    logic [31:0]      limit_reg, limit_next;
    logic [5:0]       bits_reg, bits_next;

    logic             ram_we;
    logic [MT_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    logic [MT_AW-1:0] nxt_idx, far_idx;
    logic [MT_AW:0]   far_sum;
    logic [31:0]      seed_old, seed_new, base_cur;
    logic [31:0]      mix_y, twisted, tempered, draw_r;
    logic [5:0]       bits_sat;
    logic             draw_ok, seed_last;

    mtsb_word_ram #(
        .DEPTH(MT_N),
        .WIDTH(32),
        .AW   (MT_AW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Neighbor and far indexes of the element being twisted.
    assign nxt_idx = (pos_reg == MT_AW'(MT_N - 1)) ? '0 : pos_reg + MT_AW'(1);
    assign far_sum = {1'b0, pos_reg} + (MT_AW + 1)'(MT_M);
    assign far_idx = (far_sum >= (MT_AW + 1)'(MT_N)) ?
                     MT_AW'(far_sum - (MT_AW + 1)'(MT_N)) : far_sum[MT_AW-1:0];

    // Seeding: pass one reads the base table, made on the fly, until the index wraps.
    assign base_cur = bprod_reg + {{(32 - MT_AW){1'b0}}, idx_reg};
    assign seed_old = (!pass_reg && !wrap_reg) ? base_cur : ram_rdata;
    assign seed_new = pass_reg ?
                      ((seed_old ^ prod_reg) - {{(32 - MT_AW){1'b0}}, idx_reg}) :
                      ((seed_old ^ prod_reg) + key_reg);
    assign seed_last = pass_reg && (cnt_reg == MT_AW'(MT_N - 2));

    // Drawing.
    assign mix_y    = (cur_reg & MT_UPPER) | (nw_reg & MT_LOWER);
    assign twisted  = ram_rdata ^ (mix_y >> 1) ^ (mix_y[0] ? MT_MATRIX : 32'd0);
    assign tempered = mt_temper(twisted);
    assign bits_sat = (bits_reg > 6'd32) ? 6'd32 : bits_reg;
    assign draw_r   = (bits_sat == 6'd0) ? 32'd0 : (tempered >> (6'd32 - bits_sat));
    assign draw_ok  = (kind_reg == KIND_RAW) || (limit_reg == 32'd0) || (draw_r < limit_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.valid) begin
                    if (cmd.kind == KIND_SEED) begin
                        state_next = ST_SEED_RD;
                    end else if (cmd.kind == KIND_RAW || cmd.kind == KIND_BOUNDED) begin
                        state_next = ST_DRAW_RN;
                    end
                end
            end
            ST_SEED_RD:  state_next = ST_SEED_WR;
            ST_SEED_WR:  state_next = seed_last ? ST_SEED_FIN : ST_SEED_RD;
            ST_SEED_FIN: state_next = ST_IDLE;
            ST_DRAW_RN:  state_next = ST_DRAW_RF;
            ST_DRAW_RF:  state_next = ST_DRAW_CMP;
            ST_DRAW_CMP: begin
                if (out_free || !draw_ok) begin
                    state_next = draw_ok ? ST_IDLE : ST_DRAW_RN;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        wrap_next  = wrap_reg;
        p_next     = p_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        bprod_next = bprod_reg;
        key_next   = key_reg;
        cur_next   = cur_reg;
        nw_next    = nw_reg;
        kind_next  = kind_reg;
        limit_next = limit_reg;
        bits_next  = bits_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = twisted;
        ram_raddr  = nxt_idx;
        stat.ready     = (state_reg == ST_IDLE);
        stat.res_valid = 1'b0;
        stat.res_value = (kind_reg == KIND_RAW) ? tempered : draw_r;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.valid) begin
                    kind_next  = cmd.kind;
                    limit_next = cmd.limit;
                    bits_next  = cmd.bits;
                    key_next   = cmd.seed;
                    idx_next   = MT_AW'(1);
                    cnt_next   = '0;
                    pass_next  = 1'b0;
                    wrap_next  = 1'b0;
                    p_next     = BASE_SEED;
                    b_next     = BASE_SEED;
                end
            end
            ST_SEED_RD: begin
                ram_raddr  = idx_reg;
                prod_next  = (p_reg ^ (p_reg >> 30)) * (pass_reg ? MULT_MIX2 : MULT_MIX1);
                bprod_next = (b_reg ^ (b_reg >> 30)) * MULT_BASE;
            end
            ST_SEED_WR: begin
                ram_raddr = idx_reg;
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = seed_new;
                p_next    = seed_new;
                b_next    = base_cur;
                if (idx_reg == MT_AW'(MT_N - 1)) begin
                    idx_next  = MT_AW'(1);
                    wrap_next = 1'b1;
                end else begin
                    idx_next = idx_reg + MT_AW'(1);
                end
                if (!pass_reg && cnt_reg == MT_AW'(MT_N - 1)) begin
                    pass_next = 1'b1;
                    cnt_next  = '0;
                end else begin
                    cnt_next = cnt_reg + MT_AW'(1);
                end
            end
            ST_SEED_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = MT_UPPER;
                pos_next  = '0;
                cur_next  = MT_UPPER;
            end
            ST_DRAW_RN: begin
                ram_raddr = nxt_idx;
            end
            ST_DRAW_RF: begin
                ram_raddr = far_idx;
                nw_next   = ram_rdata;
            end
            ST_DRAW_CMP: begin
                ram_raddr = far_idx;
                // A rejected attempt moves on at once; only a result waits for the register.
                if (out_free || !draw_ok) begin
                    ram_we         = 1'b1;
                    cur_next       = nw_reg;
                    pos_next       = nxt_idx;
                    stat.res_valid = draw_ok;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        pass_reg  <= pass_next;
        wrap_reg  <= wrap_next;
        p_reg     <= p_next;
        b_reg     <= b_next;
        prod_reg  <= prod_next;
        bprod_reg <= bprod_next;
        key_reg   <= key_next;
        cur_reg   <= cur_next;
        nw_reg    <= nw_next;
        kind_reg  <= kind_next;
        limit_reg <= limit_next;
        bits_reg  <= bits_next;
    end

endmodule

### rtl/core/mt19937_seeded_bounded_draws_unit.sv
// MT19937 generator with single-integer seeding and bounded rejection draws.
// The slave channel carries one request per transaction: s_tuser selects a
// reseed, a raw draw or a bounded draw, and s_tdata carries the seed, the
// exclusive limit and the number of top word bits used per bounded attempt.
// The master channel returns one 32-bit value per raw or bounded draw; a
// reseed and the unused kind return nothing.
// The 624-word state lives in one synchronous memory with one read and one
// write port. A draw reads the neighbor word and then the far word, and
// twists, tempers and writes back in its compare step, from which a raw
// draw's result goes to the output register; a bounded draw repeats these
// steps for every attempt, rejected attempts included. A reseed walks 1247
// mixing steps, each a read and then a modify and write, plus one final
// step that writes word 0, and s_tready stays low throughout.
// Reset clears the sequencer and the draw position; the words are undefined
// until the first reseed, so a draw must not come before one.
// Results wait in an output register. A stalled receiver holds the last
// result there while the next request is accepted; that request stops at
// its final attempt until the register is free again.
module mt19937_seeded_bounded_draws_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // seed[31:0], limit[63:32], bits[69:64], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // value[31:0]
);
    import mtsb_pkg::*;

    mtsb_cmd_t  cmd;
    mtsb_stat_t stat;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        out_free;

    assign s_tready   = stat.ready;
    assign cmd.valid  = s_tvalid && stat.ready;
    assign cmd.kind   = s_tuser;
    assign cmd.seed   = s_tdata[31:0];
    assign cmd.limit  = s_tdata[63:32];
    assign cmd.bits   = s_tdata[69:64];

    // The core may commit a result whenever the register is empty or empties this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    mtsb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .out_free(out_free),
        .stat    (stat)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (stat.res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = stat.res_value;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/core/mtsb_checker.sv
`include "assert_macros.svh"

module mtsb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import mtsb_pkg::*;

    logic seed_acc, draw_acc;

    assign seed_acc = s_tvalid && s_tready && (s_tuser == KIND_SEED);
    assign draw_acc = s_tvalid && s_tready && (s_tuser == KIND_RAW || s_tuser == KIND_BOUNDED);

    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `CHK_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_tvalid, "result valid after reset")
    `CHK_NEXT(a_seed_busy, aclk, aresetn, seed_acc, !s_tready, "reseed did not block input")
    `CHK_NEXT(a_draw_busy, aclk, aresetn, draw_acc, !s_tready, "draw did not block input")
    `CHK_IMPL(a_result_src, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result appeared while idle")

endmodule

bind mt19937_seeded_bounded_draws_unit mtsb_checker u_mtsb_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mtsb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;    // seed[31:0], limit[63:32], bits[69:64], zero pad
    logic [1:0]  s_tuser;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // value[31:0]

    mt19937_seeded_bounded_draws_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // One request as the sender offers it, with an optional typed-in answer.
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] seed;
        logic [31:0] limit;
        logic [5:0]  bits;
        bit          known;
        logic [31:0] value;
    } request_t;

    // Predictor state: the working words, the fixed start table and the position.
    logic [31:0] gen_words [MT_N];
    logic [31:0] start_table [MT_N];
    int unsigned gen_pos;

    logic [31:0] pending_values [$];
    int          fail_count;
    bit          stim_done;
    bit          hold_off;
    int unsigned accepted_results;

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    function automatic void build_start_table();
        logic [31:0] p;
        start_table[0] = BASE_SEED;
        for (int i = 1; i < MT_N; i++) begin
            p = start_table[i - 1];
            start_table[i] = MULT_BASE * (p ^ (p >> 30)) + 32'(i);
        end
    endfunction

    // CPython-style init_by_array with a one-word key.
    function automatic void reseed_words(input logic [31:0] key);
        int unsigned i;
        logic [31:0] p;
        i = 1;
        for (int n = 0; n < MT_N; n++) gen_words[n] = start_table[n];
        for (int k = 0; k < MT_N; k++) begin
            p = gen_words[i - 1];
            gen_words[i] = (gen_words[i] ^ ((p ^ (p >> 30)) * MULT_MIX1)) + key;
            i++;
            if (i >= MT_N) begin
                gen_words[0] = gen_words[MT_N - 1];
                i = 1;
            end
        end
        for (int k = 0; k < MT_N - 1; k++) begin
            p = gen_words[i - 1];
            gen_words[i] = (gen_words[i] ^ ((p ^ (p >> 30)) * MULT_MIX2)) - 32'(i);
            i++;
            if (i >= MT_N) begin
                gen_words[0] = gen_words[MT_N - 1];
                i = 1;
            end
        end
        gen_words[0] = MT_UPPER;
        gen_pos = 0;
    endfunction

    // Twists a single element in place and returns its tempered form.
    function automatic logic [31:0] twist_next();
        int unsigned nx, fr;
        logic [31:0] y;
        nx = (gen_pos + 1) % MT_N;
        fr = (gen_pos + MT_M) % MT_N;
        y = (gen_words[gen_pos] & MT_UPPER) | (gen_words[nx] & MT_LOWER);
        y = gen_words[fr] ^ (y >> 1) ^ ({32{y[0]}} & MT_MATRIX);
        gen_words[gen_pos] = y;
        gen_pos = nx;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] bounded_value(input logic [31:0] lim,
                                                  input logic [5:0] nbits);
        int unsigned b;
        logic [31:0] w, r;
        b = (nbits > 32) ? 32 : nbits;
        forever begin
            w = twist_next();
            r = (b == 0) ? 32'd0 : 32'(w >> (32 - b));
            if (lim == 0 || r < lim) return r;
        end
    endfunction

    // Works out the expected outcome of one accepted transaction.
    function automatic void predict_request(input request_t rq);
        logic [31:0] v;
        case (rq.kind)
            KIND_SEED: begin
                reseed_words(rq.seed);
                return;
            end
            KIND_RAW: begin
                v = twist_next();
            end
            KIND_BOUNDED: begin
                v = bounded_value(rq.limit, rq.bits);
            end
            default: begin
                return;
            end
        endcase
        if (rq.known && v !== rq.value) begin
            $display("%0t: table answer disagrees, expected %h predicted %h",
                     $time, rq.value, v);
            fail_count++;
        end
        pending_values = {pending_values, v};
    endfunction

    // Gap lengths: mostly none or short, now and then long.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    request_t directed [$];

    // Called at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high.
    task automatic send_request(input request_t rq);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {2'b00, rq.bits, rq.limit, rq.seed};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(rq);
        @(negedge aclk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge aclk);
        end
    endtask

    function automatic request_t mk(input logic [1:0] k, input logic [31:0] s,
                                    input logic [31:0] l, input logic [5:0] b);
        request_t rq;
        rq.kind = k; rq.seed = s; rq.limit = l; rq.bits = b;
        rq.known = 1'b0; rq.value = '0;
        return rq;
    endfunction

    function automatic request_t random_request();
        int r;
        int unsigned eb;
        logic [5:0] b;
        logic [31:0] l;
        r = $urandom_range(0, 99);
        if (r < 3) return mk(KIND_SEED, $urandom(), $urandom(), 6'($urandom()));
        if (r < 5) return mk(KIND_UNUSED, $urandom(), $urandom(), 6'($urandom()));
        if (r < 45) return mk(KIND_RAW, $urandom(), $urandom(), 6'($urandom()));
        // Bounded: pick bits and a limit that keeps rejection cheap on average.
        case ($urandom_range(0, 5))
            0: b = 6'($urandom_range(0, 63));
            default: b = 6'($urandom_range(1, 32));
        endcase
        case ($urandom_range(0, 3))
            0: l = $urandom();
            1: l = 32'($urandom_range(1, 1000));
            2: l = 32'd0;
            default: l = (b >= 32 || b == 0) ? $urandom()
                         : ((32'd1 << b) - 32'($urandom_range(0, 3)));
        endcase
        if (l == 0 && $urandom_range(0, 1)) l = 32'd1;
        // Keep the limit at least half of the reachable range so attempts stay few.
        eb = (b > 32) ? 32 : b;
        if (l != 0 && eb != 0 && l < (32'd1 << (eb - 1))) l = 32'd1 << (eb - 1);
        return mk(KIND_BOUNDED, $urandom(), l, b);
    endfunction

    // Sender.
    initial begin
        request_t rq;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        fail_count = 0;
        stim_done  = 1'b0;
        build_start_table();
        for (int n = 0; n < MT_N; n++) gen_words[n] = '0;
        gen_pos = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: field extremes, every kind, each special case.
        rq = mk(KIND_SEED, 32'd0, 32'd0, 6'd0);           directed = {directed, rq};
        rq = mk(KIND_RAW, '0, '0, '0);                    directed = {directed, rq};
        rq = mk(KIND_SEED, 32'd1, '1, 6'h3f);             directed = {directed, rq};
        rq = mk(KIND_RAW, '1, '1, 6'h3f);                 directed = {directed, rq};
        directed = {directed, mk(KIND_SEED, 32'hffff_ffff, 32'd5, 6'd7)};
        directed = {directed, mk(KIND_RAW, '0, '0, '0)};
        // Zero bits always gives zero on the first attempt.
        rq = mk(KIND_BOUNDED, '0, 32'd1, 6'd0); rq.known = 1'b1; rq.value = 32'd0;
        directed = {directed, rq};
        // Zero limit accepts the first attempt.
        directed = {directed, mk(KIND_BOUNDED, '0, 32'd0, 6'd32)};
        directed = {directed, mk(KIND_BOUNDED, '0, 32'hffff_ffff, 6'd32)};
        directed = {directed, mk(KIND_BOUNDED, '1, 32'd1, 6'd1)};
        directed = {directed, mk(KIND_BOUNDED, '0, 32'd2, 6'd1)};
        // Bits above 32 saturate.
        directed = {directed, mk(KIND_BOUNDED, '0, 32'd0, 6'd33)};
        directed = {directed, mk(KIND_BOUNDED, '0, 32'h8000_0000, 6'd63)};
        directed = {directed, mk(KIND_BOUNDED, '0, 32'd3, 6'd2)};
        // Unused kind is dropped and leaves the sequence alone.
        directed = {directed, mk(KIND_UNUSED, '1, '1, 6'h3f)};
        directed = {directed, mk(KIND_RAW, '0, '0, '0)};
        directed = {directed, mk(KIND_SEED, 32'h8000_0001, 32'd0, 6'd0)};
        directed = {directed, mk(KIND_BOUNDED, '0, 32'd100, 6'd8)};
        directed = {directed, mk(KIND_RAW, '0, '0, '0)};
        foreach (directed[i]) begin
            send_request(directed[i]);
            idle_gap(gap_cycles());
        end

        // Random part; bursts with no gap keep the pipe busy.
        for (int n = 0; n < 700; n++) begin
            send_request(random_request());
            if (n % 100 < 70) idle_gap(gap_cycles());
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver with random stalls and one long hold-off early in the random part.
    initial begin
        int stall;
        hold_off = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_off && accepted_results == 40) begin
                hold_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            stall = gap_cycles();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker.
    initial accepted_results = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            accepted_results <= accepted_results + 1;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                if (m_tdata !== pending_values[0]) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, pending_values[0], m_tdata);
                    fail_count++;
                end
                void'(pending_values.pop_front());
            end
        end
    end

    // Drain, settle and report.
    initial begin
        wait (stim_done);
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        if (fail_count == 0 && pending_values.size() == 0) begin
            $display("mt19937_seeded_bounded_draws_unit regression: pass");
        end else begin
            $display("mt19937_seeded_bounded_draws_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, pending_values.size());
        $display("mt19937_seeded_bounded_draws_unit regression: fail");
        $finish;
    end
endmodule
